// ===== sv/gsa_pkg.sv =====
// Shared constants, operation and status codes, and transfer types of the slot allocator.
package gsa_pkg;

    // Built capacity and handle widths.
    localparam int MAX_SLOTS = 64;
    localparam int GEN_BITS  = 16;
    localparam int IDX_W     = $clog2(MAX_SLOTS);
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int KIND_W    = 3;
    localparam int STATUS_W  = 2;

    // Operation codes carried in the kind field.
    localparam logic [KIND_W-1:0] KIND_INIT    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CREATE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LOOKUP  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DESTROY = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TICK    = 3'd4;

    // Status codes returned with every result.
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_FREE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

    // One request on the input channel.
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [IDX_W-1:0]    slot_index;
        logic [GEN_BITS-1:0] handle_generation;
    } slot_req_t;

    // One result on the output channel.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    granted_index;
        logic [GEN_BITS-1:0] granted_generation;
        logic                handle_live;
    } slot_rsp_t;

endpackage

// ===== sv/generational_slot_allocator_unit.sv =====
// Generational handle table: free stack, generation memory, destroy queue and sequencer.
//
// Usage: requests arrive on s_valid/s_ready/s_data, one result per request leaves on
// m_valid/m_ready/m_data. cfg_we/cfg_wdata write the slot count; it takes effect at the
// next initialize request. A small sequencer steps one shared set of memories, each with
// one read and one write port (free stack, generations, destroy queue), so one request is
// in flight at a time and s_ready is high only while the sequencer is idle.
// Lookup and destroy read the generation and then check the handle; create reads the
// stack, then the generation; create on an empty stack and unused kinds go straight to
// the result. Tick reads each queue entry and then pushes it. Initialize sweeps every
// built slot, one a cycle. The next request is accepted at the earliest in the cycle
// after m_valid rises. Reset clears the control state and then runs the same sweep
// with s_ready low; it produces no result. A finished result sits in the output
// register while a new request is accepted; when the receiver stalls, the next
// finished result waits in the sequencer until the output register is free.
module generational_slot_allocator_unit (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  gsa_pkg::slot_req_t       s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output gsa_pkg::slot_rsp_t       m_data,
    input  logic                     cfg_we,
    input  logic [gsa_pkg::CNT_W-1:0] cfg_wdata
);
    import gsa_pkg::*;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SWEEP   = 3'd1;
    localparam logic [2:0] ST_CHECK   = 3'd2;
    localparam logic [2:0] ST_POP     = 3'd3;
    localparam logic [2:0] ST_GRANT   = 3'd4;
    localparam logic [2:0] ST_TICK_RD = 3'd5;
    localparam logic [2:0] ST_TICK_WR = 3'd6;
    localparam logic [2:0] ST_DONE    = 3'd7;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SLOTS);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    // Control state.
    logic [2:0]           state_reg, state_next;
    logic [CNT_W-1:0]     slots_cfg_reg;
    logic [CNT_W-1:0]     active_reg, active_next;
    logic [CNT_W-1:0]     free_count_reg, free_count_next;
    logic [CNT_W-1:0]     destroy_count_reg, destroy_count_next;
    logic [CNT_W-1:0]     sweep_idx_reg, sweep_idx_next;
    logic                 init_reply_reg, init_reply_next;
    logic [MAX_SLOTS-1:0] slot_occupied_reg, slot_occupied_next;
    logic [MAX_SLOTS-1:0] slot_queued_reg, slot_queued_next;
    logic                 m_valid_reg, m_valid_next;

    // Payload state.
    slot_req_t            req_reg, req_next;
    slot_rsp_t            result_reg, result_next;
    slot_rsp_t            m_data_reg, m_data_next;
    logic [CNT_W-1:0]     tick_idx_reg, tick_idx_next;

    // Memories and their registered read data.
    logic [GEN_BITS-1:0]  gen_mem_reg [MAX_SLOTS];
    logic [IDX_W-1:0]     stack_mem_reg [MAX_SLOTS];
    logic [IDX_W-1:0]     dq_mem_reg [MAX_SLOTS];
    logic [GEN_BITS-1:0]  gen_rd_reg;
    logic [IDX_W-1:0]     stack_rd_reg;
    logic [IDX_W-1:0]     dq_rd_reg;

    // Memory port controls.
    logic                 gen_we, stack_we, dq_we;
    logic [IDX_W-1:0]     gen_wa, gen_ra, stack_wa, stack_ra, dq_wa, dq_ra;
    logic [GEN_BITS-1:0]  gen_wd;
    logic [IDX_W-1:0]     stack_wd, dq_wd;

    logic [CNT_W-1:0]     clamped_slots;
    logic                 handle_ok;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The configured count limited to the built range.
    always_comb begin
        priority if (slots_cfg_reg == '0) begin
            clamped_slots = CNT_ONE;
        end else if (slots_cfg_reg > CNT_MAX) begin
            clamped_slots = CNT_MAX;
        end else begin
            clamped_slots = slots_cfg_reg;
        end
    end

    // Handle check against the generation read for the latched request.
    assign handle_ok = (CNT_W'(req_reg.slot_index) < active_reg)
                    && (gen_rd_reg == req_reg.handle_generation)
                    && slot_occupied_reg[req_reg.slot_index]
                    && !slot_queued_reg[req_reg.slot_index];

    // Sequencer next-state and memory port selection.
    always_comb begin
        state_next         = state_reg;
        active_next        = active_reg;
        free_count_next    = free_count_reg;
        destroy_count_next = destroy_count_reg;
        sweep_idx_next     = sweep_idx_reg;
        init_reply_next    = init_reply_reg;
        slot_occupied_next = slot_occupied_reg;
        slot_queued_next   = slot_queued_reg;
        m_valid_next       = m_valid_reg;
        req_next           = req_reg;
        result_next        = result_reg;
        m_data_next        = m_data_reg;
        tick_idx_next      = tick_idx_reg;

        gen_we   = 1'b0;
        gen_wa   = req_reg.slot_index;
        gen_wd   = gen_rd_reg + GEN_BITS'(1);
        gen_ra   = s_data.slot_index;
        stack_we = 1'b0;
        stack_wa = free_count_reg[IDX_W-1:0];
        stack_wd = dq_rd_reg;
        stack_ra = IDX_W'(free_count_reg - CNT_ONE);
        dq_we    = 1'b0;
        dq_wa    = destroy_count_reg[IDX_W-1:0];
        dq_wd    = req_reg.slot_index;
        dq_ra    = tick_idx_reg[IDX_W-1:0];

        // The receiver takes the current result.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next      = s_data;
                    result_next   = '0;
                    tick_idx_next = '0;
                    unique case (s_data.kind)
                        KIND_INIT: begin
                            active_next        = clamped_slots;
                            free_count_next    = clamped_slots;
                            destroy_count_next = '0;
                            slot_occupied_next = '0;
                            slot_queued_next   = '0;
                            sweep_idx_next     = '0;
                            init_reply_next    = 1'b1;
                            state_next         = ST_SWEEP;
                        end
                        KIND_CREATE: begin
                            if (free_count_reg == '0) begin
                                result_next.status = STATUS_NO_FREE;
                                state_next         = ST_DONE;
                            end else begin
                                state_next = ST_POP;
                            end
                        end
                        KIND_LOOKUP, KIND_DESTROY: begin
                            state_next = ST_CHECK;
                        end
                        KIND_TICK: begin
                            state_next = ST_TICK_RD;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            // Rebuild: identity free stack and zero generations, one slot a cycle.
            ST_SWEEP: begin
                gen_we   = 1'b1;
                gen_wa   = sweep_idx_reg[IDX_W-1:0];
                gen_wd   = '0;
                stack_we = 1'b1;
                stack_wa = sweep_idx_reg[IDX_W-1:0];
                stack_wd = sweep_idx_reg[IDX_W-1:0];
                if (sweep_idx_reg == CNT_MAX - CNT_ONE) begin
                    init_reply_next = 1'b0;
                    state_next      = init_reply_reg ? ST_DONE : ST_IDLE;
                end else begin
                    sweep_idx_next = sweep_idx_reg + CNT_ONE;
                end
            end

            // Lookup reports the check; destroy also bumps the generation and queues.
            ST_CHECK: begin
                if (req_reg.kind == KIND_LOOKUP) begin
                    if (handle_ok) begin
                        result_next.handle_live = 1'b1;
                    end else begin
                        result_next.status = STATUS_INVALID;
                    end
                end else begin
                    if (!handle_ok || destroy_count_reg >= CNT_MAX) begin
                        result_next.status = STATUS_INVALID;
                    end else begin
                        gen_we = 1'b1;
                        dq_we  = 1'b1;
                        slot_queued_next[req_reg.slot_index] = 1'b1;
                        destroy_count_next = destroy_count_reg + CNT_ONE;
                    end
                end
                state_next = ST_DONE;
            end

            // The popped index is granted; its generation is read next.
            ST_POP: begin
                free_count_next                 = free_count_reg - CNT_ONE;
                slot_occupied_next[stack_rd_reg] = 1'b1;
                slot_queued_next[stack_rd_reg]   = 1'b0;
                gen_ra                          = stack_rd_reg;
                result_next.granted_index       = stack_rd_reg;
                state_next                      = ST_GRANT;
            end

            ST_GRANT: begin
                result_next.granted_generation = gen_rd_reg;
                state_next                     = ST_DONE;
            end

            // Drain: read the next queue entry, or finish when the queue is empty.
            ST_TICK_RD: begin
                if (tick_idx_reg < destroy_count_reg) begin
                    state_next = ST_TICK_WR;
                end else begin
                    destroy_count_next = '0;
                    state_next         = ST_DONE;
                end
            end

            // Release the queued slot and push it back onto the free stack.
            ST_TICK_WR: begin
                slot_occupied_next[dq_rd_reg] = 1'b0;
                slot_queued_next[dq_rd_reg]   = 1'b0;
                if (free_count_reg < CNT_MAX) begin
                    stack_we        = 1'b1;
                    free_count_next = free_count_reg + CNT_ONE;
                end
                tick_idx_next = tick_idx_reg + CNT_ONE;
                state_next    = ST_TICK_RD;
            end

            // Hand the result to the output register once it is free.
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = result_reg;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_SWEEP;
            slots_cfg_reg     <= CNT_MAX;
            active_reg        <= CNT_MAX;
            free_count_reg    <= CNT_MAX;
            destroy_count_reg <= '0;
            sweep_idx_reg     <= '0;
            init_reply_reg    <= 1'b0;
            slot_occupied_reg <= '0;
            slot_queued_reg   <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            active_reg        <= active_next;
            free_count_reg    <= free_count_next;
            destroy_count_reg <= destroy_count_next;
            sweep_idx_reg     <= sweep_idx_next;
            init_reply_reg    <= init_reply_next;
            slot_occupied_reg <= slot_occupied_next;
            slot_queued_reg   <= slot_queued_next;
            m_valid_reg       <= m_valid_next;
            if (cfg_we) begin
                slots_cfg_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        result_reg   <= result_next;
        m_data_reg   <= m_data_next;
        tick_idx_reg <= tick_idx_next;
    end

    // Generation memory.
    always_ff @(posedge aclk) begin
        if (gen_we) begin
            gen_mem_reg[gen_wa] <= gen_wd;
        end
        gen_rd_reg <= gen_mem_reg[gen_ra];
    end

    // Free stack memory.
    always_ff @(posedge aclk) begin
        if (stack_we) begin
            stack_mem_reg[stack_wa] <= stack_wd;
        end
        stack_rd_reg <= stack_mem_reg[stack_ra];
    end

    // Destroy queue memory.
    always_ff @(posedge aclk) begin
        if (dq_we) begin
            dq_mem_reg[dq_wa] <= dq_wd;
        end
        dq_rd_reg <= dq_mem_reg[dq_ra];
    end

`ifndef NO_ASSERTIONS
    // A queued slot is always still occupied.
    a_queued_occupied: assert property (@(posedge aclk) disable iff (!aresetn)
        (slot_queued_reg & ~slot_occupied_reg) == '0)
        else $error("queued slot is not occupied");

    // Between requests the queue length matches the queued flags.
    a_queue_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> ($countones(slot_queued_reg) == int'(destroy_count_reg)))
        else $error("destroy count disagrees with queued slots");

    // Between requests every managed slot is either free or occupied.
    a_slot_balance: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE)
        |-> ((int'(free_count_reg) + $countones(slot_occupied_reg)) == int'(active_reg)))
        else $error("free and occupied slots do not add up");

    // The free count never exceeds the managed slot count.
    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        free_count_reg <= active_reg)
        else $error("free count above managed slot count");
`endif

endmodule
